// File: hw/rtl/olc_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list with cursor: shared types
// Command, error and cell operation codes, and the transaction structs.
// ----------------------------------------------------------------------------
package olc_pkg;

   typedef enum logic [3:0] {
      CMD_START     = 4'd0,
      CMD_END       = 4'd1,
      CMD_LAST      = 4'd2,
      CMD_ADVANCE   = 4'd3,
      CMD_RETREAT   = 4'd4,
      CMD_INSERT    = 4'd5,
      CMD_ATTACH    = 4'd6,
      CMD_REMOVE    = 4'd7,
      CMD_INS_FRONT = 4'd8,
      CMD_ATT_BACK  = 4'd9,
      CMD_REM_FRONT = 4'd10,
      CMD_READ_CUR  = 4'd11,
      CMD_READ_IDX  = 4'd12
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_FULL       = 2'd1,
      ERR_NO_CURRENT = 2'd2,
      ERR_RANGE      = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] entry_value;
      logic [4:0]  read_position;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [5:0]  item_count;
      logic [5:0]  cursor_position;
      logic        has_current;
      logic [1:0]  error_code;
   } rsp_type;

endpackage

// File: hw/rtl/olc_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list slot. On an insert it loads the new word or takes its left
// neighbor's word; on a remove it takes its right neighbor's word.
// ----------------------------------------------------------------------------
module olc_cell
   import olc_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int CW        = 6,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  cell_op_type          op,
   input  logic [CW-1:0]        op_pos,
   input  logic [WORD_BITS-1:0] new_word,
   input  logic [WORD_BITS-1:0] left_word,
   input  logic [WORD_BITS-1:0] right_word,
   input  logic [CW-1:0]        read_addr,
   output logic [WORD_BITS-1:0] word_q,
   output logic [WORD_BITS-1:0] read_word
);

   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic [WORD_BITS-1:0] data_ff;
   logic [WORD_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_INSERT: begin
            if (MY_INDEX == op_pos) begin
               data_in = new_word;
            end else if (MY_INDEX > op_pos) begin
               data_in = left_word;
            end
         end
         CELL_REMOVE: begin
            if (MY_INDEX >= op_pos) begin
               data_in = right_word;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word_q    = data_ff;
   assign read_word = (read_addr == MY_INDEX) ? data_ff : '0;

endmodule

// File: hw/rtl/ordered_list_with_cursor_unit.sv
// Response: registered in the output register in the cycle after the request is accepted.
// Throughput: one transaction per cycle for every command unless a held response stalls
// requests; the row of cells shifts all entries at once, so inserts and removes keep that rate.
// Reset: synchronous; count and cursor clear to zero, entry contents stay undefined.
// ----------------------------------------------------------------------------
// Ordered list with cursor
// Fixed-capacity ordered list held in a row of cells, with a cursor and
// one response per command.
// ----------------------------------------------------------------------------
module ordered_list_with_cursor_unit
   import olc_pkg::*;
#(
   parameter int CAPACITY_ENTRIES = 32,
   parameter int WORD_BITS        = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
   localparam logic [CW-1:0] CAP_VAL  = CW'(CAPACITY_ENTRIES);
   localparam logic [CW-1:0] LAST_POS = CW'(CAPACITY_ENTRIES - 1);
   localparam logic [CW-1:0] ONE      = CW'(1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 cur_ok;
   logic                 full;
   cell_op_type          op;
   cell_op_type          cell_op;
   logic [CW-1:0]        op_pos;
   logic [CW-1:0]        read_addr;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] read_all;
   logic [63:0]          read_wide;
   err_type              err;
   logic [31:0]          rd;

   logic [WORD_BITS-1:0] cell_q  [CAPACITY_ENTRIES];
   logic [WORD_BITS-1:0] cell_rd [CAPACITY_ENTRIES];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign cur_ok    = cursor_ff < count_ff;
   assign full      = count_ff >= CAP_VAL;
   assign new_word  = WORD_BITS'(64'(req_data.entry_value));
   assign cell_op   = accept ? op : CELL_HOLD;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY_ENTRIES; gi++) begin : g_cell
         olc_cell #(
            .INDEX     (gi),
            .CW        (CW),
            .WORD_BITS (WORD_BITS)
         ) u_cell (
            .clock      (clock),
            .op         (cell_op),
            .op_pos     (op_pos),
            .new_word   (new_word),
            .left_word  (cell_q[(gi == 0) ? 0 : gi - 1]),
            .right_word (cell_q[(gi == CAPACITY_ENTRIES - 1) ? gi : gi + 1]),
            .read_addr  (read_addr),
            .word_q     (cell_q[gi]),
            .read_word  (cell_rd[gi])
         );
      end
   endgenerate

   always_comb begin
      read_all = '0;
      for (int i = 0; i < CAPACITY_ENTRIES; i++) begin
         read_all = read_all | cell_rd[i];
      end
   end

   assign read_wide = 64'(read_all);

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      op        = CELL_HOLD;
      op_pos    = cursor_ff;
      err       = ERR_NONE;
      rd        = '0;
      read_addr = cursor_ff;
      case (cmd_type'(req_data.cmd))
         CMD_START: begin
            cursor_in = '0;
         end
         CMD_END: begin
            cursor_in = (count_ff != '0) ? count_ff - ONE : '0;
         end
         CMD_LAST: begin
            cursor_in = LAST_POS;
         end
         CMD_ADVANCE: begin
            if (!cur_ok) begin
               err = ERR_NO_CURRENT;
            end else begin
               cursor_in = cursor_ff + ONE;
            end
         end
         CMD_RETREAT: begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - ONE;
            end
         end
         CMD_INSERT: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               op        = CELL_INSERT;
               op_pos    = cur_ok ? cursor_ff : '0;
               cursor_in = op_pos;
               count_in  = count_ff + ONE;
            end
         end
         CMD_ATTACH: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               op        = CELL_INSERT;
               op_pos    = cur_ok ? cursor_ff + ONE : count_ff;
               cursor_in = op_pos;
               count_in  = count_ff + ONE;
            end
         end
         CMD_REMOVE: begin
            if (!cur_ok) begin
               err = ERR_NO_CURRENT;
            end else begin
               op       = CELL_REMOVE;
               op_pos   = cursor_ff;
               count_in = count_ff - ONE;
            end
         end
         CMD_INS_FRONT: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               op        = CELL_INSERT;
               op_pos    = '0;
               cursor_in = '0;
               count_in  = count_ff + ONE;
            end
         end
         CMD_ATT_BACK: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               op        = CELL_INSERT;
               op_pos    = count_ff;
               cursor_in = count_ff;
               count_in  = count_ff + ONE;
            end
         end
         CMD_REM_FRONT: begin
            if (!cur_ok) begin
               err = ERR_NO_CURRENT;
            end else begin
               op        = CELL_REMOVE;
               op_pos    = '0;
               cursor_in = '0;
               count_in  = count_ff - ONE;
            end
         end
         CMD_READ_CUR: begin
            if (!cur_ok) begin
               err = ERR_NO_CURRENT;
            end else begin
               rd = read_wide[31:0];
            end
         end
         CMD_READ_IDX: begin
            read_addr = CW'(req_data.read_position);
            if (32'(req_data.read_position) >= 32'(count_ff)) begin
               err = ERR_RANGE;
            end else begin
               rd = read_wide[31:0];
            end
         end
         default: begin
            err = ERR_NONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_value      = rd;
         rsp_data_in.item_count      = 6'(count_in);
         rsp_data_in.cursor_position = 6'(cursor_in);
         rsp_data_in.has_current     = cursor_in < count_in;
         rsp_data_in.error_code      = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
